@@ src/arpc_pkg.sv @@
// Shared constants and types for the ARP address cache.
// No dependencies; imported by arp_cache_learn_resolve.
package arpc_pkg;

    localparam int ENTRIES_DEF = 16;

    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int TIME_W  = 32;
    localparam int LIFE_W  = 16;
    localparam int STAT_W  = 3;
    localparam int OIDX_W  = 4;

    // stream payload widths (packed, padded to bytes)
    localparam int S_TDATA_W = 152;
    localparam int M_TDATA_W = 56;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_OWN_IP   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIFETIME = 1'd1;

    localparam logic [IP_W-1:0]   LOOPBACK_IP    = 32'h7F00_0001;
    localparam logic [LIFE_W-1:0] LIFETIME_RESET = 16'd300;

    localparam logic ACT_LEARN   = 1'b0;
    localparam logic ACT_RESOLVE = 1'b1;

    localparam logic [STAT_W-1:0] STAT_HIT     = 3'd0;
    localparam logic [STAT_W-1:0] STAT_LOCAL   = 3'd1;
    localparam logic [STAT_W-1:0] STAT_MISS    = 3'd2;
    localparam logic [STAT_W-1:0] STAT_LEARNED = 3'd3;
    localparam logic [STAT_W-1:0] STAT_FULL    = 3'd4;

    typedef struct packed {
        logic [TIME_W-1:0] seen;
        logic [MAC_W-1:0]  mac;
        logic [IP_W-1:0]   ip;
    } slot_t;

endpackage

@@ src/arp_cache_learn_resolve.sv @@
// ARP address cache with aging: learn and resolve over a slot memory.
// Depends on arpc_pkg.
//
// channel   dir   handshake            payload
// s_*       in    s_tvalid/s_tready    tuser: action; tdata: ip, mac, target, req, now
// m_*       out   m_tvalid/m_tready    tuser: status; tdata: index, mac, reply
// cfg_*     in    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item at a time. A scan reads one slot a cycle from the slot memory
// into a registered read-data register and compares it the next cycle.
// Local resolves (own IP or loopback) skip the scan and go straight to DONE.
// Reset clears valid bits and control registers; slot and data regs are not cleared.
// The result register lets a new item be accepted while the last result waits;
// a finished item holds in DONE while that register is still occupied.
module arp_cache_learn_resolve
#(
    parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [0] action
    input  logic                            s_tuser,
    // [31:0] ip_addr, [79:32] mac_addr, [111:80] target,
    // [112] is_request, [144:113] now_seconds, [151:145] zero
    input  logic [arpc_pkg::S_TDATA_W-1:0]  s_tdata,

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [2:0] status
    output logic [arpc_pkg::STAT_W-1:0]     m_tuser,
    // [3:0] entry_index, [51:4] found_mac, [52] send_reply, [55:53] zero
    output logic [arpc_pkg::M_TDATA_W-1:0]  m_tdata,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [arpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [arpc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import arpc_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    // configuration
    logic [IP_W-1:0]   own_ip_reg;
    logic [LIFE_W-1:0] lifetime_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg   <= '0;
            lifetime_reg <= LIFETIME_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_OWN_IP:   own_ip_reg   <= cfg_data;
                REG_LIFETIME: lifetime_reg <= cfg_data[LIFE_W-1:0];
                default: ;
            endcase
        end
    end

    // input fields
    logic [IP_W-1:0]   in_ip;
    logic [MAC_W-1:0]  in_mac;
    logic [IP_W-1:0]   in_target;
    logic              in_req;
    logic [TIME_W-1:0] in_now;

    assign in_ip     = s_tdata[31:0];
    assign in_mac    = s_tdata[79:32];
    assign in_target = s_tdata[111:80];
    assign in_req    = s_tdata[112];
    assign in_now    = s_tdata[144:113];

    // control and item registers
    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  rd_cnt_reg, rd_cnt_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;

    logic              act_reg, act_next;
    logic [IP_W-1:0]   ip_reg, ip_next;
    logic [MAC_W-1:0]  mac_reg, mac_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic              reply_reg, reply_next;

    logic [STAT_W-1:0] res_stat_reg, res_stat_next;
    logic [OIDX_W-1:0] res_idx_reg, res_idx_next;
    logic [MAC_W-1:0]  res_mac_reg, res_mac_next;
    logic              res_reply_reg, res_reply_next;

    logic              out_vld_reg, out_vld_next;
    logic [STAT_W-1:0] out_stat_reg, out_stat_next;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;

    // slot memory
    slot_t             mem [ENTRIES];
    slot_t             rd_data_reg;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    slot_t             wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[cmp_idx_reg] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign wr_data = '{seen: now_reg, mac: mac_reg, ip: ip_reg};

    // compare stage
    logic              slot_vld;
    logic              ip_eq;
    logic [TIME_W-1:0] age;
    logic              young;
    logic              match;
    logic              last_slot;

    assign slot_vld  = valid_reg[cmp_idx_reg];
    assign ip_eq     = (rd_data_reg.ip == ip_reg);
    assign age       = now_reg - rd_data_reg.seen;
    assign young     = (age < TIME_W'(lifetime_reg));
    assign match     = (act_reg == ACT_LEARN) ? (!slot_vld || ip_eq)
                                              : (slot_vld && ip_eq && young);
    assign last_slot = (cmp_idx_reg == IDX_W'(ENTRIES - 1));

    assign s_tready = (state_reg == S_IDLE);
    assign rd_en    = (state_reg == S_SCAN) && (rd_cnt_reg != CNT_W'(ENTRIES));
    assign rd_addr  = rd_cnt_reg[IDX_W-1:0];
    assign wr_en    = (state_reg == S_SCAN) && cmp_vld_reg && match
                      && (act_reg == ACT_LEARN);

    always_comb
    begin
        state_next     = state_reg;
        rd_cnt_next    = rd_cnt_reg;
        cmp_vld_next   = cmp_vld_reg;
        cmp_idx_next   = cmp_idx_reg;
        valid_next     = valid_reg;
        act_next       = act_reg;
        ip_next        = ip_reg;
        mac_next       = mac_reg;
        now_next       = now_reg;
        reply_next     = reply_reg;
        res_stat_next  = res_stat_reg;
        res_idx_next   = res_idx_reg;
        res_mac_next   = res_mac_reg;
        res_reply_next = res_reply_reg;
        out_vld_next   = out_vld_reg;
        out_stat_next  = out_stat_reg;
        out_data_next  = out_data_reg;

        if (out_vld_reg && m_tready)
        begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    act_next     = s_tuser;
                    ip_next      = in_ip;
                    mac_next     = in_mac;
                    now_next     = in_now;
                    reply_next   = (s_tuser == ACT_LEARN) && in_req
                                   && (in_target == own_ip_reg);
                    rd_cnt_next  = '0;
                    cmp_vld_next = 1'b0;
                    if ((s_tuser == ACT_RESOLVE)
                        && ((in_ip == own_ip_reg) || (in_ip == LOOPBACK_IP)))
                    begin
                        res_stat_next  = STAT_LOCAL;
                        res_idx_next   = '0;
                        res_mac_next   = '0;
                        res_reply_next = 1'b0;
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (rd_en)
                begin
                    rd_cnt_next  = rd_cnt_reg + CNT_W'(1);
                    cmp_idx_next = rd_addr;
                end
                cmp_vld_next = rd_en;

                if (cmp_vld_reg && match)
                begin
                    res_idx_next   = OIDX_W'(cmp_idx_reg);
                    res_reply_next = reply_reg;
                    if (act_reg == ACT_LEARN)
                    begin
                        valid_next[cmp_idx_reg] = 1'b1;
                        res_stat_next = STAT_LEARNED;
                        res_mac_next  = '0;
                    end
                    else
                    begin
                        res_stat_next = STAT_HIT;
                        res_mac_next  = rd_data_reg.mac;
                    end
                    cmp_vld_next = 1'b0;
                    state_next   = S_DONE;
                end
                else if (cmp_vld_reg && last_slot)
                begin
                    res_stat_next  = (act_reg == ACT_LEARN) ? STAT_FULL : STAT_MISS;
                    res_idx_next   = '0;
                    res_mac_next   = '0;
                    res_reply_next = reply_reg;
                    cmp_vld_next   = 1'b0;
                    state_next     = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_vld_reg || m_tready)
                begin
                    out_vld_next  = 1'b1;
                    out_stat_next = res_stat_reg;
                    out_data_next = {3'b000, res_reply_reg, res_mac_reg, res_idx_reg};
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            rd_cnt_reg  <= '0;
            cmp_vld_reg <= 1'b0;
            valid_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_cnt_reg  <= rd_cnt_next;
            cmp_vld_reg <= cmp_vld_next;
            valid_reg   <= valid_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg   <= cmp_idx_next;
        act_reg       <= act_next;
        ip_reg        <= ip_next;
        mac_reg       <= mac_next;
        now_reg       <= now_next;
        reply_reg     <= reply_next;
        res_stat_reg  <= res_stat_next;
        res_idx_reg   <= res_idx_next;
        res_mac_reg   <= res_mac_next;
        res_reply_reg <= res_reply_next;
        out_stat_reg  <= out_stat_next;
        out_data_reg  <= out_data_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_stat_reg;
    assign m_tdata  = out_data_reg;

endmodule
